// ===== rtl/swtf_pkg.sv =====
// Shared types and constants for the sliding-window top-frequency sum block.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package swtf_pkg;

  localparam int SUM_W    = 38;
  localparam int CFG_W    = 7;
  localparam int CFG_IDX_W = 8;
  localparam int IN_W     = 32;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_LEN = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_COUNT  = 8'd1;

  localparam logic [CFG_W-1:0] WINDOW_LEN_RST = 7'd64;
  localparam logic [CFG_W-1:0] TOP_COUNT_RST  = 7'd2;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVCHK,
    ST_EV_LD,
    ST_INS,
    ST_SRCH_RD,
    ST_SRCH_CK,
    ST_DN_RD,
    ST_DN_CK,
    ST_DN_END,
    ST_UP_RD,
    ST_UP_CK,
    ST_SUM0,
    ST_SUM_RD,
    ST_SUM_CK
  } swtf_state_t;

  typedef struct packed {
    logic idle;
    logic emit;
  } swtf_stat_t;

endpackage

`default_nettype wire

// ===== rtl/swtf_if.sv =====
// Channel interfaces: input word, result word and configuration write.
// Depends on swtf_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface swtf_in_if import swtf_pkg::*;;
  logic            valid;
  logic            ready;
  logic [IN_W-1:0] value;
  logic            start_new;
  modport source (output valid, value, start_new, input ready);
  modport sink   (input valid, value, start_new, output ready);
endinterface

interface swtf_out_if import swtf_pkg::*;;
  logic             valid;
  logic             ready;
  logic [SUM_W-1:0] weighted_sum;
  modport source (output valid, weighted_sum, input ready);
  modport sink   (input valid, weighted_sum, output ready);
endinterface

interface swtf_cfg_if import swtf_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_W-1:0]     data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/sliding_window_top_frequency_sum.sv =====
// Top level: configuration registers, result register and the update core.
// Depends on swtf_pkg, swtf_if and swtf_core.
`timescale 1ns / 1ps
`default_nettype none

// Keeps the last window_len values and a rank table of distinct values sorted
// by count (ties: larger value first); when the window is full each word yields
// the sum of count*value over the top_count leading entries. One word is in
// work at a time. Every step is a read of the rank table memory, which has
// separate read and write addresses, followed by a check. Up to two evictions
// happen per word, each a search and a bubble down the table; the insert
// searches and bubbles up through the table; the sum then reads the leading
// entries. No clearing pass is needed after reset or start_new. A result
// waits in an output register, so the next input word can be taken while it
// waits; a later result holds the core in its sum until that register is
// free.
module sliding_window_top_frequency_sum import swtf_pkg::*; #(
  parameter int WINDOW_MAX = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  swtf_in_if.sink     in_ch,
  swtf_out_if.source  out_ch,
  swtf_cfg_if.sink    cfg_ch
);

  localparam int CW = $clog2(WINDOW_MAX + 1);

  logic [CFG_W-1:0] window_len_r, top_count_r;
  logic             out_valid_r, out_valid_nxt;
  logic [SUM_W-1:0] out_sum_r;
  logic [31:0]      wlen32;
  logic [CW-1:0]    wl;
  logic             out_free;
  swtf_stat_t       stat;
  logic [SUM_W-1:0] core_sum;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_len_r <= WINDOW_LEN_RST;
      top_count_r  <= TOP_COUNT_RST;
    end else if (cfg_ch.valid) begin
      if (cfg_ch.index == REG_WINDOW_LEN) window_len_r <= cfg_ch.data;
      if (cfg_ch.index == REG_TOP_COUNT)  top_count_r  <= cfg_ch.data;
    end
  end

  // zero acts as one, anything above the ring depth as the full ring
  assign wlen32 = 32'(window_len_r);
  assign wl = (wlen32 == 32'd0) ? CW'(1) :
              (wlen32 > WINDOW_MAX) ? CW'(WINDOW_MAX) : CW'(wlen32);

  assign in_ch.ready = stat.idle;
  assign out_free    = !out_valid_r || out_ch.ready;

  swtf_core #(
    .WINDOW_MAX (WINDOW_MAX),
    .VALUE_BITS (VALUE_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .wl        (wl),
    .top_count (top_count_r),
    .go        (in_ch.valid && stat.idle),
    .value     (in_ch.value[VALUE_BITS-1:0]),
    .start_new (in_ch.start_new),
    .out_free  (out_free),
    .stat      (stat),
    .sum       (core_sum)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_ch.ready) out_valid_nxt = 1'b0;
    if (stat.emit) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (stat.emit) out_sum_r <= core_sum;
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.weighted_sum = out_sum_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken while a word is still in work");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |-> (!out_valid_r || out_ch.ready))
    else $error("result register overwritten before it was taken");

  a_emit_loads: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit |=> (out_valid_r && out_sum_r == $past(core_sum)))
    else $error("result word not presented after emit");

endmodule

`default_nettype wire

// ===== rtl/swtf_core.sv =====
// Window ring and rank table memories with the sequencer that updates them.
// Depends on swtf_pkg.
`timescale 1ns / 1ps
`default_nettype none

module swtf_core import swtf_pkg::*; #(
  parameter int WINDOW_MAX = 64,
  parameter int VALUE_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic [$clog2(WINDOW_MAX+1)-1:0]   wl,
  input  logic [CFG_W-1:0]                  top_count,
  input  logic                              go,
  input  logic [VALUE_BITS-1:0]             value,
  input  logic                              start_new,
  input  logic                              out_free,
  output swtf_stat_t                        stat,
  output logic [SUM_W-1:0]                  sum
);

  localparam int CW  = $clog2(WINDOW_MAX + 1);
  localparam int IW  = $clog2(WINDOW_MAX);
  localparam int EW  = CW + VALUE_BITS;

  logic [VALUE_BITS-1:0] win_mem [WINDOW_MAX];
  logic [EW-1:0]         tbl_mem [WINDOW_MAX];

  swtf_state_t state_r, state_nxt;
  logic [CW-1:0]         fill_r, fill_nxt;
  logic [IW-1:0]         wp_r, wp_nxt;
  logic [CW-1:0]         dist_r, dist_nxt;
  logic [CW-1:0]         i_r, i_nxt;
  logic [CW-1:0]         n_r, n_nxt;
  logic [VALUE_BITS-1:0] val_r, val_nxt;
  logic [VALUE_BITS-1:0] key_r, key_nxt;
  logic [EW-1:0]         cur_r, cur_nxt;
  logic                  stage_r, stage_nxt;
  logic                  evm_r, evm_nxt;
  logic [SUM_W-1:0]      acc_r, acc_nxt;
  logic [SUM_W-1:0]      prod_r, prod_nxt;

  logic                  win_we;
  logic [IW-1:0]         win_raddr;
  logic [VALUE_BITS-1:0] win_rdata_r;
  logic                  tbl_we;
  logic [IW-1:0]         tbl_waddr, tbl_raddr;
  logic [EW-1:0]         tbl_wdata, tbl_rdata_r;

  logic [CW:0]           old_ext;
  logic                  ev_need;
  logic [EW-1:0]         mul;
  logic [31:0]           top32, dist32;

  always_ff @(posedge clk) begin
    if (win_we) begin
      win_mem[wp_r] <= val_r;
    end
    win_rdata_r <= win_mem[win_raddr];
  end

  always_ff @(posedge clk) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    tbl_rdata_r <= tbl_mem[tbl_raddr];
  end

  // oldest slot of the ring
  always_comb begin
    old_ext = (CW+1)'(wp_r) + (CW+1)'(WINDOW_MAX) - (CW+1)'(fill_r);
    if (old_ext >= (CW+1)'(WINDOW_MAX)) begin
      old_ext = old_ext - (CW+1)'(WINDOW_MAX);
    end
  end

  assign ev_need = stage_r ? (fill_r >= wl) : (fill_r > wl);
  assign mul     = EW'(tbl_rdata_r[EW-1 -: CW]) * EW'(tbl_rdata_r[VALUE_BITS-1:0]);
  assign top32   = 32'(top_count);
  assign dist32  = 32'(dist_r);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:    if (go) state_nxt = ST_EVCHK;
      ST_EVCHK: begin
        if (ev_need) state_nxt = ST_EV_LD;
        else if (stage_r) state_nxt = ST_INS;
      end
      ST_EV_LD:   state_nxt = ST_SRCH_RD;
      ST_INS:     state_nxt = ST_SRCH_RD;
      ST_SRCH_RD: begin
        if (i_r < dist_r) state_nxt = ST_SRCH_CK;
        else if (!evm_r) state_nxt = ST_UP_RD;
        else if (stage_r) state_nxt = ST_INS;
        else state_nxt = ST_EVCHK;
      end
      ST_SRCH_CK: begin
        if (tbl_rdata_r[VALUE_BITS-1:0] == key_r) begin
          state_nxt = evm_r ? ST_DN_RD : ST_UP_RD;
        end else begin
          state_nxt = ST_SRCH_RD;
        end
      end
      ST_DN_RD:   state_nxt = (i_r + 1'b1 < dist_r) ? ST_DN_CK : ST_DN_END;
      ST_DN_CK:   state_nxt = (tbl_rdata_r > cur_r) ? ST_DN_RD : ST_DN_END;
      ST_DN_END:  state_nxt = stage_r ? ST_INS : ST_EVCHK;
      ST_UP_RD:   state_nxt = (i_r != '0) ? ST_UP_CK : ST_SUM0;
      ST_UP_CK:   state_nxt = (cur_r > tbl_rdata_r) ? ST_UP_RD : ST_SUM0;
      ST_SUM0:    state_nxt = (fill_r == wl) ? ST_SUM_RD : ST_IDLE;
      ST_SUM_RD: begin
        if (i_r < n_r) state_nxt = ST_SUM_CK;
        else if (out_free) state_nxt = ST_IDLE;
      end
      ST_SUM_CK:  state_nxt = ST_SUM_RD;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    fill_nxt  = fill_r;
    wp_nxt    = wp_r;
    dist_nxt  = dist_r;
    i_nxt     = i_r;
    n_nxt     = n_r;
    val_nxt   = val_r;
    key_nxt   = key_r;
    cur_nxt   = cur_r;
    stage_nxt = stage_r;
    evm_nxt   = evm_r;
    acc_nxt   = acc_r;
    prod_nxt  = prod_r;
    win_we    = 1'b0;
    win_raddr = IW'(old_ext);
    tbl_we    = 1'b0;
    tbl_waddr = i_r[IW-1:0];
    tbl_wdata = cur_r;
    tbl_raddr = i_r[IW-1:0];
    stat.idle = (state_r == ST_IDLE);
    stat.emit = 1'b0;
    sum       = acc_r + prod_r;
    case (state_r)
      ST_IDLE: begin
        if (go) begin
          val_nxt   = value;
          stage_nxt = 1'b0;
          if (start_new) begin
            fill_nxt = '0;
            wp_nxt   = '0;
            dist_nxt = '0;
          end
        end
      end
      ST_EVCHK: begin
        if (ev_need) evm_nxt = 1'b1;
        else stage_nxt = 1'b1;
      end
      ST_EV_LD: begin
        key_nxt = win_rdata_r;
        i_nxt   = '0;
      end
      ST_INS: begin
        win_we  = 1'b1;
        wp_nxt  = (wp_r == IW'(WINDOW_MAX - 1)) ? '0 : wp_r + 1'b1;
        fill_nxt = fill_r + 1'b1;
        key_nxt = val_r;
        i_nxt   = '0;
        evm_nxt = 1'b0;
      end
      ST_SRCH_RD: begin
        if (i_r >= dist_r) begin
          if (evm_r) begin
            // value missing from the table: just drop it from the window
            fill_nxt  = fill_r - 1'b1;
            stage_nxt = 1'b1;
          end else begin
            cur_nxt  = {CW'(1), key_r};
            dist_nxt = dist_r + 1'b1;
          end
        end
      end
      ST_SRCH_CK: begin
        if (tbl_rdata_r[VALUE_BITS-1:0] == key_r) begin
          cur_nxt = evm_r ? tbl_rdata_r - {CW'(1), VALUE_BITS'(0)}
                          : tbl_rdata_r + {CW'(1), VALUE_BITS'(0)};
        end else begin
          i_nxt = i_r + 1'b1;
        end
      end
      ST_DN_RD: begin
        tbl_raddr = IW'(i_r + 1'b1);
        if (!(i_r + 1'b1 < dist_r)) tbl_we = 1'b1;
      end
      ST_DN_CK: begin
        tbl_we = 1'b1;
        if (tbl_rdata_r > cur_r) begin
          tbl_wdata = tbl_rdata_r;
          i_nxt     = i_r + 1'b1;
        end
      end
      ST_DN_END: begin
        if (cur_r[EW-1 -: CW] == '0 && dist_r != '0) dist_nxt = dist_r - 1'b1;
        fill_nxt  = fill_r - 1'b1;
        stage_nxt = 1'b1;
      end
      ST_UP_RD: begin
        tbl_raddr = IW'(i_r - 1'b1);
        if (i_r == '0) tbl_we = 1'b1;
      end
      ST_UP_CK: begin
        tbl_we = 1'b1;
        if (cur_r > tbl_rdata_r) begin
          tbl_wdata = tbl_rdata_r;
          i_nxt     = i_r - 1'b1;
        end
      end
      ST_SUM0: begin
        i_nxt    = '0;
        acc_nxt  = '0;
        prod_nxt = '0;
        n_nxt    = (top32 > dist32) ? dist_r : CW'(top32);
      end
      ST_SUM_RD: begin
        acc_nxt  = acc_r + prod_r;
        prod_nxt = '0;
        if (!(i_r < n_r) && out_free) stat.emit = 1'b1;
      end
      ST_SUM_CK: begin
        prod_nxt = SUM_W'(mul);
        i_nxt    = i_r + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      fill_r  <= '0;
      wp_r    <= '0;
      dist_r  <= '0;
      stage_r <= 1'b0;
      evm_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      wp_r    <= wp_nxt;
      dist_r  <= dist_nxt;
      stage_r <= stage_nxt;
      evm_r   <= evm_nxt;
    end
  end

  always_ff @(posedge clk) begin
    i_r    <= i_nxt;
    n_r    <= n_nxt;
    val_r  <= val_nxt;
    key_r  <= key_nxt;
    cur_r  <= cur_nxt;
    acc_r  <= acc_nxt;
    prod_r <= prod_nxt;
  end

endmodule

`default_nettype wire

// ===== sim/tb_sliding_window_top_frequency_sum.sv =====
// Testbench for the sliding-window top-frequency sum block: directed and random words,
// configuration phases and output back-pressure, checked against a local predictor.
// Depends on swtf_pkg, swtf_if and the block's RTL.
`timescale 1ns / 1ps

module tb_sliding_window_top_frequency_sum;
  import swtf_pkg::*;

  localparam int WMAX = 64;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  swtf_in_if  in_ch ();
  swtf_out_if out_ch ();
  swtf_cfg_if cfg_ch ();

  sliding_window_top_frequency_sum #(.WINDOW_MAX(WMAX), .VALUE_BITS(32)) i_dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch), .cfg_ch(cfg_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [CFG_W-1:0] win_len_reg;
  logic [CFG_W-1:0] top_cnt_reg;
  logic [31:0]      ring [WMAX];
  int               wr_ptr;
  int               fill;
  logic [31:0]      tbl_val [WMAX];
  int               tbl_cnt [WMAX];
  int               n_distinct;

  logic [SUM_W-1:0] sum_queue [$];
  int  errors = 0;
  int  n_words = 0;
  int  n_sums = 0;
  bit  hold_out = 1'b0;

  function automatic bit above(int a, int b);
    if (tbl_cnt[a] != tbl_cnt[b]) return tbl_cnt[a] > tbl_cnt[b];
    return tbl_val[a] > tbl_val[b];
  endfunction

  function automatic void swap_rows(int a, int b);
    logic [31:0] tv;
    int tc;
    tv = tbl_val[a]; tc = tbl_cnt[a];
    tbl_val[a] = tbl_val[b]; tbl_cnt[a] = tbl_cnt[b];
    tbl_val[b] = tv; tbl_cnt[b] = tc;
  endfunction

  function automatic int lookup(logic [31:0] v);
    for (int i = 0; i < n_distinct; i++)
      if (tbl_val[i] == v) return i;
    return n_distinct;
  endfunction

  function automatic void clear_window();
    for (int i = 0; i < WMAX; i++) tbl_cnt[i] = 0;
    wr_ptr = 0;
    fill = 0;
    n_distinct = 0;
  endfunction

  function automatic void drop_oldest();
    int i;
    if (fill == 0) return;
    i = lookup(ring[(wr_ptr + WMAX - fill) % WMAX]);
    fill--;
    if (i >= n_distinct || tbl_cnt[i] == 0) return;
    tbl_cnt[i]--;
    while (i + 1 < n_distinct && above(i + 1, i)) begin
      swap_rows(i, i + 1);
      i++;
    end
    if (tbl_cnt[i] == 0) n_distinct--;
  endfunction

  function automatic void predict_sum(logic [31:0] v, bit restart);
    int wl, i, n;
    logic [63:0] acc;
    wl = win_len_reg;
    if (wl == 0) wl = 1;
    if (wl > WMAX) wl = WMAX;
    if (restart) clear_window();
    if (fill > wl) drop_oldest();
    if (fill >= wl) drop_oldest();
    ring[wr_ptr] = v;
    wr_ptr = (wr_ptr + 1) % WMAX;
    fill++;
    i = lookup(v);
    if (i == n_distinct) begin
      tbl_val[i] = v;
      tbl_cnt[i] = 0;
      n_distinct++;
    end
    tbl_cnt[i]++;
    while (i > 0 && above(i, i - 1)) begin
      swap_rows(i, i - 1);
      i--;
    end
    if (fill != wl) return;
    n = top_cnt_reg;
    if (n > n_distinct) n = n_distinct;
    acc = 0;
    for (i = 0; i < n; i++) acc += 64'(tbl_cnt[i]) * 64'(tbl_val[i]);
    sum_queue = {sum_queue, acc[SUM_W-1:0]};
  endfunction

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // result checker; hold off for a random gap after each word
  initial begin
    int g;
    g = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (sum_queue.size() == 0) begin
          $error("weighted_sum: unexpected word, actual %0d", out_ch.weighted_sum);
          errors++;
        end else begin
          logic [SUM_W-1:0] exp_sum;
          exp_sum = sum_queue.pop_front();
          n_sums++;
          if (out_ch.weighted_sum !== exp_sum) begin
            $error("weighted_sum: expected %0d, actual %0d", exp_sum, out_ch.weighted_sum);
            errors++;
          end
        end
        g = gap_len();
      end
      if (g > 0) begin
        g--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= !hold_out;
      end
    end
  end

  task automatic send_word(logic [31:0] v, bit restart);
    int g;
    g = gap_len();
    if (g > 0) begin
      in_ch.valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= v;
    in_ch.start_new <= restart;
    do @(posedge clk); while (!in_ch.ready);
    predict_sum(v, restart);
    n_words++;
  endtask

  // wait for all results, then let any word without a result finish its update
  task automatic drain();
    in_ch.valid <= 1'b0;
    while (sum_queue.size() != 0) @(posedge clk);
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] d);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= d;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    if (idx == REG_WINDOW_LEN) win_len_reg = d;
    else top_cnt_reg = d;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_value(int pool);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return 32'hFFFF_FFFF - $urandom_range(0, pool);
      default: return $urandom_range(0, pool);
    endcase
  endfunction

  task automatic test_defaults();
    // default window 64, top 2: fill the window with extreme values
    send_word(32'hFFFF_FFFF, 1'b1);
    for (int i = 1; i < 66; i++)
      send_word((i % 3 == 0) ? 32'h0 : (i % 3 == 1) ? 32'hFFFF_FFFF : 32'hAAAA_5555, 1'b0);
    drain();
  endtask

  task automatic test_directed();
    write_reg(REG_WINDOW_LEN, 7'd3);
    write_reg(REG_TOP_COUNT, 7'd0);
    send_word(32'd5, 1'b1);
    send_word(32'd5, 1'b0);
    send_word(32'd7, 1'b0);
    send_word(32'd9, 1'b0);
    drain();
    write_reg(REG_TOP_COUNT, 7'd127);
    send_word(32'd5, 1'b0);
    send_word(32'd5, 1'b0);
    send_word(32'h5555_AAAA, 1'b1);
    send_word(32'd1, 1'b0);
    send_word(32'd1, 1'b0);
    drain();
    // shorten window while filled
    write_reg(REG_WINDOW_LEN, 7'd1);
    send_word(32'd3, 1'b0);
    send_word(32'd4, 1'b0);
    send_word(32'd4, 1'b0);
    drain();
    write_reg(REG_WINDOW_LEN, 7'd0);
    send_word(32'd8, 1'b0);
    send_word(32'hFFFF_FFFF, 1'b0);
    drain();
    write_reg(REG_WINDOW_LEN, 7'd127);
    write_reg(REG_TOP_COUNT, 7'd1);
    send_word(32'd2, 1'b1);
    drain();
  endtask

  task automatic test_random(int count);
    int wl, pool;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: wl = $urandom_range(1, 6);
        1: wl = $urandom_range(7, 20);
        2: wl = 64;
        default: wl = $urandom_range(0, 127);
      endcase
      write_reg(REG_WINDOW_LEN, wl[CFG_W-1:0]);
      write_reg(REG_TOP_COUNT, CFG_W'($urandom_range(0, 9) == 0 ?
                $urandom_range(0, 127) : $urandom_range(1, 5)));
      pool = (ph % 2) ? 7 : 40;
      for (int i = 0; i < count / 8; i++)
        send_word(rand_value(pool), (i == 0) || ($urandom_range(0, 60) == 0));
      drain();
    end
  endtask

  task automatic test_backpressure();
    // receiver holds off while words keep coming
    write_reg(REG_WINDOW_LEN, 7'd2);
    write_reg(REG_TOP_COUNT, 7'd2);
    fork
      begin
        hold_out = 1'b1;
        repeat (3000) @(posedge clk);
        hold_out = 1'b0;
      end
      for (int i = 0; i < 30; i++) send_word($urandom(), i == 0);
    join
    drain();
  endtask

  initial begin
    in_ch.valid <= 1'b0;
    in_ch.value <= '0;
    in_ch.start_new <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= '0;
    cfg_ch.data <= '0;
    win_len_reg = WINDOW_LEN_RST;
    top_cnt_reg = TOP_COUNT_RST;
    clear_window();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_defaults();
    test_directed();
    test_random(400);
    test_backpressure();
    $display("Sent %0d words, checked %0d sums across window/top settings and a long stall.",
             n_words, n_sums);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #80ms;
    $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/swtf_pkg.sv
rtl/swtf_if.sv
rtl/swtf_core.sv
rtl/sliding_window_top_frequency_sum.sv
sim/tb_sliding_window_top_frequency_sum.sv
